// ===== src/rrfm_pkg.sv =====
// Package with shared types and constants for the reconciled rank-filtered mean unit.
package rrfm_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int ROW_W = 34;
  localparam int KEY_W = 17;

  localparam logic [15:0] KEEP_THRESHOLD_RST = 16'd983;
  localparam logic [16:0] MIN_KEPT_PORTION_RST = 17'd43254;

  localparam logic CFG_KEEP_THRESHOLD = 1'b0;
  localparam logic CFG_MIN_KEPT_PORTION = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_CHECK,
    S_ISSUE_I,
    S_LATCH_I,
    S_SCAN,
    S_PLACE,
    S_MERGE_INIT,
    S_MERGE,
    S_DIV_UNF_GO,
    S_DIV_UNF_WAIT,
    S_DIV_FIL_GO,
    S_DIV_FIL_WAIT,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic next_dir;
    logic issue_i;
    logic latch_i;
    logic scan;
    logic place;
    logic merge_init;
    logic merge;
    logic div_start;
    logic div_latch;
    logic div_sel;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic i_done;
    logic sdir;
    logic scan_done;
    logic merge_done;
    logic div_done;
  } ctrl_stat_t;

  // Row layout: distance present, distance, bound present, bound.
  function automatic logic [KEY_W-1:0] sort_key(input logic [ROW_W-1:0] row);
    sort_key = row[33] ? {1'b0, row[32:17]} : {1'b1, 16'd0};
  endfunction

endpackage

// ===== src/rrfm_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module rrfm_div import rrfm_pkg::*; #(
  parameter int DW = 25,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [DW-1:0]   quo;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [VW:0]     sh;

  assign sh = {rem, quo[DW-1]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(DW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (run) begin
      if (sh >= {1'b0, divisor}) begin
        rem <= VW'(sh - {1'b0, divisor});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= VW'(sh);
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/rrfm_datapath.sv =====
// Datapath: row stores, counting sort by rank, rank merge, statistics and the shared divider.
module rrfm_datapath import rrfm_pkg::*; #(
  parameter int MaxRows = DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output ctrl_stat_t  stat,
  input  logic        direction,
  input  logic [15:0] row_distance,
  input  logic        row_distance_present,
  input  logic [15:0] row_lr_bound,
  input  logic        row_lr_bound_present,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  output logic [15:0] reported_mean,
  output logic        reported_mean_valid,
  output logic [15:0] other_mean,
  output logic        other_mean_valid,
  output logic [8:0]  count_dropped,
  output logic [8:0]  count_missing,
  output logic [15:0] max_all,
  output logic        max_all_valid,
  output logic [15:0] max_kept,
  output logic        max_kept_valid,
  output logic [8:0]  count_zero_bound,
  output logic        overflow
);

  localparam int AW = $clog2(MaxRows);
  localparam int CW = $clog2(MaxRows + 1);
  localparam int SW = 16 + CW;

  logic [ROW_W-1:0] fmem [MaxRows];
  logic [ROW_W-1:0] rmem [MaxRows];
  logic [ROW_W-1:0] amem [MaxRows];
  logic [ROW_W-1:0] bmem [MaxRows];

  logic [CW-1:0] fcount, rcount;
  logic          ovf;
  logic [15:0]   keep_thr;
  logic [16:0]   min_kept;

  logic [ROW_W-1:0] row_in;
  logic [ROW_W-1:0] fdata, rdata, sdata, adata, bdata, row_i;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    cur_n, nmax;
  logic             sdir, pv, mv;
  logic [CW-1:0]    idx_i, idx_j, pj, rank, mr, pr;
  logic             f_full, r_full;

  logic [SW-1:0] unf_sum, fil_sum;
  logic [CW-1:0] unf_cnt, fil_cnt, dropped, missing, zeros;
  logic [15:0]   mx_all, mx_kept, all_avg, kept_avg;
  logic [17+CW-1:0] prod;

  logic          h1, h2, take_a;
  logic [ROW_W-1:0] c;

  logic          div_done;
  logic [SW-1:0] div_q;
  logic          use_unf;

  assign row_in = {row_distance_present, row_distance, row_lr_bound_present, row_lr_bound};
  assign f_full = (fcount == CW'(MaxRows));
  assign r_full = (rcount == CW'(MaxRows));
  assign cur_n  = sdir ? rcount : fcount;
  assign nmax   = (fcount > rcount) ? fcount : rcount;
  assign sdata  = sdir ? rdata : fdata;
  assign rd_addr = cmd.issue_i ? idx_i[AW-1:0] : idx_j[AW-1:0];

  assign stat.i_done     = (idx_i == cur_n);
  assign stat.sdir       = sdir;
  assign stat.scan_done  = (idx_j == cur_n) && !pv;
  assign stat.merge_done = (mr == nmax) && !mv;
  assign stat.div_done   = div_done;

  // Configuration, fill counts and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      fcount   <= '0;
      rcount   <= '0;
      ovf      <= 1'b0;
      keep_thr <= KEEP_THRESHOLD_RST;
      min_kept <= MIN_KEPT_PORTION_RST;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_KEEP_THRESHOLD) keep_thr <= cfg_data[15:0];
        else min_kept <= cfg_data;
      end
      if (cmd.load) begin
        if (direction) begin
          if (r_full) ovf <= 1'b1;
          else rcount <= rcount + 1'b1;
        end else begin
          if (f_full) ovf <= 1'b1;
          else fcount <= fcount + 1'b1;
        end
      end
      if (cmd.report) begin
        fcount <= '0;
        rcount <= '0;
        ovf    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !direction && !f_full) fmem[fcount[AW-1:0]] <= row_in;
    if (cmd.load && direction && !r_full) rmem[rcount[AW-1:0]] <= row_in;
    fdata <= fmem[rd_addr];
    rdata <= rmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.place && !sdir) amem[rank[AW-1:0]] <= row_i;
    if (cmd.place && sdir) bmem[rank[AW-1:0]] <= row_i;
    adata <= amem[mr[AW-1:0]];
    bdata <= bmem[mr[AW-1:0]];
  end

  // Stable rank of row i: rows with a smaller key, plus earlier rows with an equal key.
  always_ff @(posedge clk) begin
    if (rst) begin
      sdir <= 1'b0;
      pv   <= 1'b0;
      mv   <= 1'b0;
    end else begin
      if (cmd.sort_init) begin
        sdir  <= 1'b0;
        idx_i <= '0;
      end
      if (cmd.next_dir) begin
        sdir  <= 1'b1;
        idx_i <= '0;
      end
      if (cmd.latch_i) begin
        row_i <= sdata;
        idx_j <= '0;
        rank  <= '0;
        pv    <= 1'b0;
      end
      if (cmd.scan) begin
        if (idx_j != cur_n) begin
          idx_j <= idx_j + 1'b1;
          pv    <= 1'b1;
          pj    <= idx_j;
        end else begin
          pv <= 1'b0;
        end
        if (pv && ((sort_key(sdata) < sort_key(row_i)) ||
                   ((sort_key(sdata) == sort_key(row_i)) && (pj < idx_i)))) begin
          rank <= rank + 1'b1;
        end
      end
      if (cmd.place) idx_i <= idx_i + 1'b1;
      if (cmd.merge_init) begin
        mr <= '0;
        mv <= 1'b0;
      end
      if (cmd.merge) begin
        if (mr != nmax) begin
          mr <= mr + 1'b1;
          mv <= 1'b1;
          pr <= mr;
        end else begin
          mv <= 1'b0;
        end
      end
    end
  end

  assign h1 = (pr < fcount) && adata[33];
  assign h2 = (pr < rcount) && bdata[33];
  assign take_a = h1 && (!h2 || (adata[32:17] <= bdata[32:17]));
  assign c = take_a ? adata : bdata;

  always_ff @(posedge clk) begin
    if (cmd.merge_init) begin
      unf_sum <= '0;
      fil_sum <= '0;
      unf_cnt <= '0;
      fil_cnt <= '0;
      dropped <= '0;
      missing <= '0;
      zeros   <= '0;
      mx_all  <= '0;
      mx_kept <= '0;
    end else if (cmd.merge && mv) begin
      if (!h1 && !h2) begin
        missing <= missing + 1'b1;
      end else begin
        if (c[16] && (c[15:0] == 16'd0)) zeros <= zeros + 1'b1;
        unf_sum <= unf_sum + SW'(c[32:17]);
        unf_cnt <= unf_cnt + 1'b1;
        if (c[32:17] > mx_all) mx_all <= c[32:17];
        if (!c[16] || (c[15:0] >= keep_thr)) begin
          fil_sum <= fil_sum + SW'(c[32:17]);
          fil_cnt <= fil_cnt + 1'b1;
          if (c[32:17] > mx_kept) mx_kept <= c[32:17];
        end else begin
          dropped <= dropped + 1'b1;
        end
      end
    end
  end

  rrfm_div #(.DW(SW), .VW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? fil_sum : unf_sum),
    .divisor  (cmd.div_sel ? fil_cnt : unf_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    prod <= min_kept * unf_cnt;
    if (cmd.div_latch && div_done) begin
      if (cmd.div_sel) kept_avg <= div_q[15:0];
      else all_avg <= div_q[15:0];
    end
  end

  always_comb begin
    if (unf_cnt == '0) use_unf = (min_kept != 17'd0);
    else use_unf = ({1'b0, fil_cnt, 16'd0} < prod);
  end

  logic unf_ok, fil_ok;
  logic [15:0] unf_val, fil_val;
  assign unf_ok  = (unf_cnt != '0);
  assign fil_ok  = (fil_cnt != '0);
  assign unf_val = unf_ok ? all_avg : 16'd0;
  assign fil_val = fil_ok ? kept_avg : 16'd0;

  assign reported_mean       = use_unf ? unf_val : fil_val;
  assign reported_mean_valid = use_unf ? unf_ok : fil_ok;
  assign other_mean          = use_unf ? fil_val : unf_val;
  assign other_mean_valid    = use_unf ? fil_ok : unf_ok;
  assign count_dropped       = 9'(dropped);
  assign count_missing       = 9'(missing);
  assign count_zero_bound    = 9'(zeros);
  assign max_all             = mx_all;
  assign max_all_valid       = unf_ok;
  assign max_kept            = mx_kept;
  assign max_kept_valid      = fil_ok;
  assign overflow            = ovf;

endmodule

// ===== src/rrfm_ctrl.sv =====
// Controller state machine that sequences loading, sorting, merging, division and the report.
module rrfm_ctrl import rrfm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       last_row,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:         if (start && last_row) state_next = S_SORT_CHECK;
      S_SORT_CHECK: begin
        if (!stat.i_done) state_next = S_ISSUE_I;
        else if (stat.sdir) state_next = S_MERGE_INIT;
      end
      S_ISSUE_I:      state_next = S_LATCH_I;
      S_LATCH_I:      state_next = S_SCAN;
      S_SCAN:         if (stat.scan_done) state_next = S_PLACE;
      S_PLACE:        state_next = S_SORT_CHECK;
      S_MERGE_INIT:   state_next = S_MERGE;
      S_MERGE:        if (stat.merge_done) state_next = S_DIV_UNF_GO;
      S_DIV_UNF_GO:   state_next = S_DIV_UNF_WAIT;
      S_DIV_UNF_WAIT: if (stat.div_done) state_next = S_DIV_FIL_GO;
      S_DIV_FIL_GO:   state_next = S_DIV_FIL_WAIT;
      S_DIV_FIL_WAIT: if (stat.div_done) state_next = S_REPORT;
      S_REPORT:       state_next = S_IDLE;
      default:        state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy          = 1'b0;
        cmd.load      = start;
        cmd.sort_init = start && last_row;
      end
      S_SORT_CHECK:   cmd.next_dir = stat.i_done && !stat.sdir;
      S_ISSUE_I:      cmd.issue_i = 1'b1;
      S_LATCH_I:      cmd.latch_i = 1'b1;
      S_SCAN:         cmd.scan = 1'b1;
      S_PLACE:        cmd.place = 1'b1;
      S_MERGE_INIT:   cmd.merge_init = 1'b1;
      S_MERGE:        cmd.merge = 1'b1;
      S_DIV_UNF_GO:   cmd.div_start = 1'b1;
      S_DIV_UNF_WAIT: cmd.div_latch = 1'b1;
      S_DIV_FIL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      S_DIV_FIL_WAIT: begin
        cmd.div_latch = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        done       = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/reconciled_rank_filtered_mean_unit.sv =====
// Top level of the reconciled rank-filtered mean unit.
// A row item that is not last is only stored; busy stays low and the next row may follow.
// A last row starts sorting: in each direction, every row's rank is found by one scan over
// its store through a single read port.
// Then the two sorted stores are merged rank by rank, two serial divisions follow, and the
// result is shown on done for one cycle; the receiver cannot stall it.
// Synchronous reset clears the fill counts, overflow, state and restores the configuration registers.
module reconciled_rank_filtered_mean_unit import rrfm_pkg::*; #(
  parameter int MaxRows = DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        direction,
  input  logic [15:0] row_distance,
  input  logic        row_distance_present,
  input  logic [15:0] row_lr_bound,
  input  logic        row_lr_bound_present,
  input  logic        last_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  output logic        done,
  output logic [15:0] reported_mean,
  output logic        reported_mean_valid,
  output logic [15:0] other_mean,
  output logic        other_mean_valid,
  output logic [8:0]  count_dropped,
  output logic [8:0]  count_missing,
  output logic [15:0] max_all,
  output logic        max_all_valid,
  output logic [15:0] max_kept,
  output logic        max_kept_valid,
  output logic [8:0]  count_zero_bound,
  output logic        overflow
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  rrfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .last_row (last_row),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  rrfm_datapath #(.MaxRows(MaxRows)) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .direction            (direction),
    .row_distance         (row_distance),
    .row_distance_present (row_distance_present),
    .row_lr_bound         (row_lr_bound),
    .row_lr_bound_present (row_lr_bound_present),
    .cfg_write            (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .reported_mean        (reported_mean),
    .reported_mean_valid  (reported_mean_valid),
    .other_mean           (other_mean),
    .other_mean_valid     (other_mean_valid),
    .count_dropped        (count_dropped),
    .count_missing        (count_missing),
    .max_all              (max_all),
    .max_all_valid        (max_all_valid),
    .max_kept             (max_kept),
    .max_kept_valid       (max_kept_valid),
    .count_zero_bound     (count_zero_bound),
    .overflow             (overflow)
  );

endmodule
